// File: rtl/disk_line_gap_and_jacobian_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disk-to-line gap block
// Checks clocked on clk; the first form is masked during rst.
// ----------------------------------------------------------------------------
`ifndef DISK_LINE_GAP_AND_JACOBIAN_DEFINES_SVH
`define DISK_LINE_GAP_AND_JACOBIAN_DEFINES_SVH

`ifndef SYNTH
// check a property outside reset
`define DLGJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dlgj assertion failed");
// check a property on every edge, reset included
`define DLGJ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dlgj assertion failed");
`else
`define DLGJ_ASSERT(lbl, prop)
`define DLGJ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/dlgj_pkg.sv
// ----------------------------------------------------------------------------
// dlgj_pkg
// Types, constants and step functions of the disk-to-line gap pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlgj_pkg;

  // quotient caps
  localparam logic [62:0] DIST_CAP = 63'h4000_0000_0000_0000;
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

  // item attributes carried through the root stages
  typedef struct packed {
    logic        deg;
    logic        neg_d;
    logic        pos_p;
    logic        neg_e;
    logic        neg_a;
    logic        neg_b;
    logic [47:0] dmag;
    logic [47:0] pmag;
    logic [47:0] emag;
    logic [31:0] amag;
    logic [31:0] bmag;
  } carry_t;

  // square root stage
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
    carry_t      c;
  } sq_t;

  // shared division stage (dist, P/n, E/n, A/n, B/n)
  typedef struct packed {
    logic        deg;
    logic        neg_d;
    logic        pos_p;
    logic        neg_e;
    logic        neg_a;
    logic        neg_b;
    logic [31:0] n;
    logic [47:0] dmag;
    logic [47:0] pmag;
    logic [47:0] emag;
    logic [31:0] amag;
    logic [31:0] bmag;
    logic        capd;
    logic        capp;
    logic        cape;
    logic [31:0] remd;
    logic [31:0] remp;
    logic [31:0] reme;
    logic [31:0] rema;
    logic [31:0] remb;
    logic [61:0] qd;
    logic [61:0] qp;
    logic [40:0] qe;
    logic [16:0] qa;
    logic [16:0] qb;
  } dv_t;

  // partial results and partial products
  typedef struct packed {
    logic               deg;
    logic               pos_p;
    logic [31:0]        n;
    logic signed [31:0] gap;
    logic signed [31:0] na;
    logic signed [31:0] nb;
    logic signed [41:0] t2s;
    logic [63:0]        pll;
    logic [62:0]        plh;
    logic [62:0]        phl;
    logic [61:0]        phh;
  } fin_t;

  // second division stage (t1)
  typedef struct packed {
    logic               deg;
    logic               pos_p;
    logic [31:0]        n;
    logic               cap;
    logic [31:0]        rem;
    logic [40:0]        lo;
    logic [40:0]        q;
    logic signed [31:0] gap;
    logic signed [31:0] na;
    logic signed [31:0] nb;
    logic signed [41:0] t2s;
  } t1_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] dvs);
    logic [32:0] r2;
    r2 = {rem, nbit};
    if (r2 >= {1'b0, dvs}) begin
      return {1'b1, 32'(r2 - {1'b0, dvs})};
    end
    return {1'b0, r2[31:0]};
  endfunction

  // bit j of a magnitude scaled by 2^16
  function automatic logic num_bit(input logic [47:0] m, input int unsigned j);
    logic [63:0] w;
    w = {m, 16'h0};
    return w[j[5:0]];
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

// File: rtl/dlgj_ifs.sv
// ----------------------------------------------------------------------------
// dlgj stream interfaces
// Valid/ready channels for the line item and the contact result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlgj_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] line_a;
  logic signed [31:0] line_b;
  logic signed [31:0] line_c;
  logic signed [31:0] rate_a;
  logic signed [31:0] rate_b;
  logic signed [31:0] rate_c;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, line_a, line_b, line_c, rate_a, rate_b, rate_c,
                  pos_x, pos_y, input ready);
  modport sink (input valid, line_a, line_b, line_c, rate_a, rate_b, rate_c,
                pos_x, pos_y, output ready);
endinterface

interface dlgj_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gap;
  logic signed [31:0] normal_a;
  logic signed [31:0] normal_b;
  logic signed [31:0] gap_rate;
  logic               degenerate;

  modport source (output valid, gap, normal_a, normal_b, gap_rate, degenerate,
                  input ready);
  modport sink (input valid, gap, normal_a, normal_b, gap_rate, degenerate,
                output ready);
endinterface

// File: rtl/disk_line_gap_and_jacobian.sv
// ----------------------------------------------------------------------------
// disk_line_gap_and_jacobian
// Gap, contact normal and gap rate of a disk against a moving line, Q16.16.
//
//   channel   dir  beat contents
//   in_ch     in   line_a..c, rate_a..c, pos_x, pos_y
//   out_ch    out  gap, normal_a, normal_b, gap_rate, degenerate
//   cfg       in   cfg_wen, cfg_wdata (radius)
//
// One beat enters per cycle unless out_ch stalls; 141 register stages: products, sums, a
// 32-stage square root, a 62-stage shared restoring divider, the t1 product, a 41-stage
// divider and the output register. rst clears every stage valid bit and the radius.
// When out_ch stalls with a beat held, the whole pipeline freezes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "disk_line_gap_and_jacobian_defines.svh"

module disk_line_gap_and_jacobian (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [30:0] cfg_wdata,
  dlgj_in_if.sink     in_ch,
  dlgj_out_if.source  out_ch
);
  import dlgj_pkg::*;

  localparam int unsigned SQ_N = 32;
  localparam int unsigned DV_N = 62;
  localparam int unsigned T1_N = 41;

  logic        en;
  logic [30:0] radius;

  // stage 1 registers
  logic               s1_vld;
  logic [63:0]        s1_aa, s1_bb;
  logic signed [63:0] s1_ax, s1_by, s1_ara, s1_brb, s1_rax, s1_rby;
  logic signed [31:0] s1_c, s1_rc;
  logic               s1_neg_a, s1_neg_b, s1_deg;
  logic [31:0]        s1_amag, s1_bmag;

  sq_t  sq_st  [0:SQ_N];
  logic sq_vld [0:SQ_N];
  dv_t  dv_st  [0:DV_N];
  logic dv_vld [0:DV_N];
  fin_t fn;
  logic fn_vld;
  t1_t  t1_st  [0:T1_N];
  logic t1_vld [0:T1_N];

  // advance the whole pipeline unless a held result is not taken
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // hold the radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_wen) begin
      radius <= cfg_wdata;
    end
  end

  // stage 1: all products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_amag  <= in_ch.line_a[31] ? 32'(-in_ch.line_a) : 32'(in_ch.line_a);
      s1_bmag  <= in_ch.line_b[31] ? 32'(-in_ch.line_b) : 32'(in_ch.line_b);
      s1_aa    <= 64'(in_ch.line_a * in_ch.line_a);
      s1_bb    <= 64'(in_ch.line_b * in_ch.line_b);
      s1_ax    <= 64'(in_ch.line_a * in_ch.pos_x);
      s1_by    <= 64'(in_ch.line_b * in_ch.pos_y);
      s1_ara   <= 64'(in_ch.line_a * in_ch.rate_a);
      s1_brb   <= 64'(in_ch.line_b * in_ch.rate_b);
      s1_rax   <= 64'(in_ch.rate_a * in_ch.pos_x);
      s1_rby   <= 64'(in_ch.rate_b * in_ch.pos_y);
      s1_c     <= in_ch.line_c;
      s1_rc    <= in_ch.rate_c;
      s1_neg_a <= in_ch.line_a[31];
      s1_neg_b <= in_ch.line_b[31];
      s1_deg   <= (in_ch.line_a == 32'sd0) && (in_ch.line_b == 32'sd0);
    end
  end

  // stage 2: floor products to Q16.16, form D, P, E and the squared norm
  logic signed [48:0] d_sum, p_sum, e_sum;
  sq_t                sq_in;

  always_comb begin
    d_sum = 49'(s1_ax >>> 16) + 49'(s1_by >>> 16) + 49'(s1_c);
    p_sum = 49'(s1_ara >>> 16) + 49'(s1_brb >>> 16);
    e_sum = 49'(s1_rax >>> 16) + 49'(s1_rby >>> 16) + 49'(s1_rc);
    sq_in.v       = s1_aa + s1_bb;
    sq_in.r       = '0;
    sq_in.c.deg   = s1_deg;
    sq_in.c.neg_d = d_sum[48];
    sq_in.c.pos_p = !p_sum[48] && (p_sum != 49'sd0);
    sq_in.c.neg_e = e_sum[48];
    sq_in.c.neg_a = s1_neg_a;
    sq_in.c.neg_b = s1_neg_b;
    sq_in.c.dmag  = d_sum[48] ? 48'(-d_sum) : 48'(d_sum);
    sq_in.c.pmag  = p_sum[48] ? 48'(-p_sum) : 48'(p_sum);
    sq_in.c.emag  = e_sum[48] ? 48'(-e_sum) : 48'(e_sum);
    sq_in.c.amag  = s1_amag;
    sq_in.c.bmag  = s1_bmag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_st[0] <= sq_in;
    end
  end

  // square root: one result bit per stage
  function automatic sq_t sq_adv(input sq_t s, input int unsigned k);
    sq_t         r;
    logic [63:0] b;
    logic [63:0] t;
    r = s;
    b = 64'd1 << (62 - 2 * k);
    t = s.r + b;
    if (s.v >= t) begin
      r.v = s.v - t;
      r.r = (s.r >> 1) + b;
    end else begin
      r.r = s.r >> 1;
    end
    return r;
  endfunction

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_st[k+1] <= sq_adv(sq_st[k], k);
      end
    end
  end

  // divider setup: caps and starting remainders
  dv_t         dv_in;
  logic [31:0] nrt;

  always_comb begin
    nrt          = sq_st[SQ_N].r[31:0];
    dv_in.deg    = sq_st[SQ_N].c.deg;
    dv_in.neg_d  = sq_st[SQ_N].c.neg_d;
    dv_in.pos_p  = sq_st[SQ_N].c.pos_p;
    dv_in.neg_e  = sq_st[SQ_N].c.neg_e;
    dv_in.neg_a  = sq_st[SQ_N].c.neg_a;
    dv_in.neg_b  = sq_st[SQ_N].c.neg_b;
    dv_in.n      = nrt;
    dv_in.dmag   = sq_st[SQ_N].c.dmag;
    dv_in.pmag   = sq_st[SQ_N].c.pmag;
    dv_in.emag   = sq_st[SQ_N].c.emag;
    dv_in.amag   = sq_st[SQ_N].c.amag;
    dv_in.bmag   = sq_st[SQ_N].c.bmag;
    dv_in.capd   = {30'h0, dv_in.dmag[47:46]} >= nrt;
    dv_in.capp   = {30'h0, dv_in.pmag[47:46]} >= nrt;
    dv_in.cape   = {9'h0, dv_in.emag[47:25]} >= nrt;
    dv_in.remd   = dv_in.capd ? 32'h0 : {30'h0, dv_in.dmag[47:46]};
    dv_in.remp   = dv_in.capp ? 32'h0 : {30'h0, dv_in.pmag[47:46]};
    dv_in.reme   = dv_in.cape ? 32'h0 : {9'h0, dv_in.emag[47:25]};
    dv_in.rema   = {1'b0, dv_in.amag[31:1]};
    dv_in.remb   = {1'b0, dv_in.bmag[31:1]};
    dv_in.qd     = '0;
    dv_in.qp     = '0;
    dv_in.qe     = '0;
    dv_in.qa     = '0;
    dv_in.qb     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_st[0] <= dv_in;
    end
  end

  // shared divider: quotient bit j of every divide still in range
  function automatic dv_t dv_adv(input dv_t s, input int unsigned j);
    dv_t         r;
    logic [32:0] t;
    r = s;
    t = div_step(s.remd, num_bit(s.dmag, j), s.n);
    r.remd = t[31:0];
    r.qd[j[5:0]] = t[32];
    t = div_step(s.remp, num_bit(s.pmag, j), s.n);
    r.remp = t[31:0];
    r.qp[j[5:0]] = t[32];
    if (j <= 40) begin
      t = div_step(s.reme, num_bit(s.emag, j), s.n);
      r.reme = t[31:0];
      r.qe[j[5:0]] = t[32];
    end
    if (j <= 16) begin
      t = div_step(s.rema, num_bit({16'h0, s.amag}, j), s.n);
      r.rema = t[31:0];
      r.qa[j[4:0]] = t[32];
      t = div_step(s.remb, num_bit({16'h0, s.bmag}, j), s.n);
      r.remb = t[31:0];
      r.qb[j[4:0]] = t[32];
    end
    return r;
  endfunction

  for (genvar i = 0; i < DV_N; i++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (en) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_st[i+1] <= dv_adv(dv_st[i], DV_N - 1 - i);
      end
    end
  end

  // apply caps and signs, split the t1 product into limbs
  fin_t               fn_in;
  logic [62:0]        dist_m, q1;
  logic [40:0]        t2m;
  logic signed [63:0] gap_diff;

  always_comb begin
    dist_m   = dv_st[DV_N].capd ? DIST_CAP : {1'b0, dv_st[DV_N].qd};
    q1       = dv_st[DV_N].capp ? DIST_CAP : {1'b0, dv_st[DV_N].qp};
    t2m      = (dv_st[DV_N].cape || (dv_st[DV_N].qe > TERM_CAP)) ? TERM_CAP
                                                                  : dv_st[DV_N].qe;
    gap_diff = $signed({1'b0, dist_m}) - $signed({33'h0, radius});
    fn_in.deg   = dv_st[DV_N].deg;
    fn_in.pos_p = dv_st[DV_N].pos_p;
    fn_in.n     = dv_st[DV_N].n;
    fn_in.gap   = sat32(gap_diff);
    fn_in.na    = (dv_st[DV_N].neg_a != dv_st[DV_N].neg_d) ? -$signed({15'h0, dv_st[DV_N].qa})
                                                           : $signed({15'h0, dv_st[DV_N].qa});
    fn_in.nb    = (dv_st[DV_N].neg_b != dv_st[DV_N].neg_d) ? -$signed({15'h0, dv_st[DV_N].qb})
                                                           : $signed({15'h0, dv_st[DV_N].qb});
    fn_in.t2s   = (dv_st[DV_N].neg_e != dv_st[DV_N].neg_d) ? -$signed({1'b0, t2m})
                                                           : $signed({1'b0, t2m});
    fn_in.pll   = q1[31:0] * dist_m[31:0];
    fn_in.plh   = q1[31:0] * dist_m[62:32];
    fn_in.phl   = q1[62:32] * dist_m[31:0];
    fn_in.phh   = q1[62:32] * dist_m[62:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_vld <= 1'b0;
    end else if (en) begin
      fn_vld <= dv_vld[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn <= fn_in;
    end
  end

  // sum the limbs, then cap check and starting remainder of t1
  t1_t          t1_in;
  logic [125:0] prod;

  always_comb begin
    prod = {fn.phh, 64'h0} + {31'h0, fn.plh, 32'h0} + {31'h0, fn.phl, 32'h0}
         + {62'h0, fn.pll};
    t1_in.deg   = fn.deg;
    t1_in.pos_p = fn.pos_p;
    t1_in.n     = fn.n;
    t1_in.cap   = prod[125:41] >= {53'h0, fn.n};
    t1_in.rem   = t1_in.cap ? 32'h0 : prod[72:41];
    t1_in.lo    = prod[40:0];
    t1_in.q     = '0;
    t1_in.gap   = fn.gap;
    t1_in.na    = fn.na;
    t1_in.nb    = fn.nb;
    t1_in.t2s   = fn.t2s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld[0] <= 1'b0;
    end else if (en) begin
      t1_vld[0] <= fn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_st[0] <= t1_in;
    end
  end

  function automatic t1_t t1_adv(input t1_t s, input int unsigned j);
    t1_t         r;
    logic [32:0] t;
    r = s;
    t = div_step(s.rem, s.lo[j[5:0]], s.n);
    r.rem = t[31:0];
    r.q[j[5:0]] = t[32];
    return r;
  endfunction

  for (genvar i = 0; i < T1_N; i++) begin : g_t1
    always_ff @(posedge clk) begin
      if (rst) begin
        t1_vld[i+1] <= 1'b0;
      end else if (en) begin
        t1_vld[i+1] <= t1_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t1_st[i+1] <= t1_adv(t1_st[i], T1_N - 1 - i);
      end
    end
  end

  // final sum and output register
  logic [40:0]        t1m;
  logic signed [41:0] t1s;
  logic signed [42:0] rate_sum;

  always_comb begin
    t1m      = (t1_st[T1_N].cap || (t1_st[T1_N].q > TERM_CAP)) ? TERM_CAP : t1_st[T1_N].q;
    t1s      = t1_st[T1_N].pos_p ? -$signed({1'b0, t1m}) : $signed({1'b0, t1m});
    rate_sum = 43'(t1s) + 43'(t1_st[T1_N].t2s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= t1_vld[T1_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.degenerate <= t1_st[T1_N].deg;
      if (t1_st[T1_N].deg) begin
        out_ch.gap      <= '0;
        out_ch.normal_a <= '0;
        out_ch.normal_b <= '0;
        out_ch.gap_rate <= '0;
      end else begin
        out_ch.gap      <= t1_st[T1_N].gap;
        out_ch.normal_a <= t1_st[T1_N].na;
        out_ch.normal_b <= t1_st[T1_N].nb;
        out_ch.gap_rate <= sat32(64'(rate_sum));
      end
    end
  end

  // checks
  logic signed [32:0] neg_radius;
  assign neg_radius = -$signed({2'b0, radius});

  `DLGJ_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_ch.valid)
  `DLGJ_ASSERT(a_norm_bound, out_ch.valid |-> (out_ch.normal_a <= 32'sd65536 && out_ch.normal_a >= -32'sd65536))
  `DLGJ_ASSERT(a_gap_floor, out_ch.valid |-> out_ch.gap >= neg_radius)
  `DLGJ_ASSERT(a_deg_zero, out_ch.valid && out_ch.degenerate |-> out_ch.gap_rate == 32'sd0 && out_ch.normal_b == 32'sd0)

endmodule
